// ===== rtl/ircmd_pkg.sv =====
// Package for the IR remote command transmitter.
// Holds field widths, configuration register indexes, framing bytes and reset values.
// No dependencies.
package ircmd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned SegDurW   = 16;
  localparam int unsigned PeriodDurW = 20;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned WordW     = 32;
  localparam int unsigned BitCntW   = 6;

  localparam int unsigned SegCntBitsDef    = 16;
  localparam int unsigned PeriodCntBitsDef = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderMark  = 3'd0,
    CfgHeaderSpace = 3'd1,
    CfgBitMark     = 3'd2,
    CfgOneSpace    = 3'd3,
    CfgZeroSpace   = 3'd4,
    CfgFramePeriod = 3'd5,
    CfgChannelBit  = 3'd6
  } cfg_idx_e;

  localparam logic [ByteW-1:0] SyncByte  = 8'hFF;
  localparam logic [ByteW-1:0] StartByte = 8'hAA;

  localparam logic [SegDurW-1:0]    HeaderMarkRst  = 16'd2000;
  localparam logic [SegDurW-1:0]    HeaderSpaceRst = 16'd2000;
  localparam logic [SegDurW-1:0]    BitMarkRst     = 16'd300;
  localparam logic [SegDurW-1:0]    OneSpaceRst    = 16'd700;
  localparam logic [SegDurW-1:0]    ZeroSpaceRst   = 16'd300;
  localparam logic [PeriodDurW-1:0] FramePeriodRst = 20'd180000;

  localparam logic [ByteW-1:0] ThrottleRst = 8'd0;
  localparam logic [ByteW-1:0] AxisRst     = 8'd63;

  localparam logic [BitCntW-1:0] FrameBits = 6'd32;

endpackage

// ===== rtl/ircmd_if.sv =====
// Valid/ready channel interfaces for the IR remote command transmitter.
// Depends on ircmd_pkg for the byte width.
interface ircmd_in_if;
  import ircmd_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface ircmd_out_if;
  logic valid;
  logic ready;
  logic ir_mark;
  logic sending;
  logic values_updated;
  modport source (output valid, output ir_mark, output sending, output values_updated,
                  input ready);
  modport sink   (input valid, input ir_mark, input sending, input values_updated,
                  output ready);
endinterface

// ===== rtl/ir_remote_command_transmitter_top.sv =====
// IR remote command transmitter: byte parser, frame period timer and
// pulse-distance envelope generator. Depends on ircmd_pkg and ircmd_if.sv.
// The result for an item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle; the result register is reloaded in the same
// cycle that its previous item is taken, so ready only drops on output stall.
// Reset clears the parser, timers and transmitter and loads the default timing.
module ir_remote_command_transmitter_top #(
  parameter int unsigned SEGMENT_COUNTER_BITS = ircmd_pkg::SegCntBitsDef,
  parameter int unsigned PERIOD_COUNTER_BITS  = ircmd_pkg::PeriodCntBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ircmd_in_if.sink                        in_ch,
  ircmd_out_if.source                     out_ch,
  input  logic                            cfg_we_i,
  input  logic [ircmd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ircmd_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ircmd_pkg::*;

  localparam int unsigned SW  = SEGMENT_COUNTER_BITS;
  localparam int unsigned PW  = PERIOD_COUNTER_BITS;
  localparam int unsigned SCW = ((SW > SegDurW) ? SW : SegDurW) + 1;
  localparam int unsigned PCW = ((PW > PeriodDurW) ? PW : PeriodDurW) + 1;
  localparam logic [SCW-1:0] SegLim    = SCW'({SW{1'b1}});
  localparam logic [PCW-1:0] PeriodLim = PCW'({PW{1'b1}});

  typedef enum logic [2:0] {
    PsSync  = 3'd0,
    PsStart = 3'd1,
    PsThr   = 3'd2,
    PsYaw   = 3'd3,
    PsPitch = 3'd4,
    PsTrim  = 3'd5
  } parse_phase_e;

  typedef enum logic [2:0] {
    TxIdle     = 3'd0,
    TxHdrMark  = 3'd1,
    TxHdrSpace = 3'd2,
    TxBitMark  = 3'd3,
    TxBitSpace = 3'd4,
    TxFooter   = 3'd5
  } tx_phase_e;

  // Configuration registers.
  logic [SegDurW-1:0]    hdr_mark_q, hdr_space_q, bit_mark_q, one_space_q, zero_space_q;
  logic [PeriodDurW-1:0] period_dur_q;
  logic                  channel_q;

  // Block state.
  parse_phase_e      parse_q, parse_d;
  logic [ByteW-1:0]  thr_q, thr_d, yaw_q, yaw_d, pitch_q, pitch_d, trim_q, trim_d;
  logic [PW-1:0]     period_cnt_q, period_cnt_d;
  logic              pending_q, pending_d;
  logic [WordW-1:0]  word_q, word_d;
  tx_phase_e         tx_q, tx_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  logic [SW-1:0]     seg_cnt_q, seg_cnt_d;

  // Result register.
  logic out_valid_q;
  logic mark_q, mark_d, busy_q, busy_d, upd_q, upd_d;

  logic accept;
  logic [PCW-1:0] p_dur;
  logic [SCW-1:0] s_dur;
  logic [SegDurW-1:0] seg_sel;
  logic p_done, s_done, active;
  logic [ByteW-1:0] thr_byte;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_q;
  assign out_ch.ir_mark        = mark_q;
  assign out_ch.sending        = busy_q;
  assign out_ch.values_updated = upd_q;

  assign thr_byte = thr_q | {channel_q, {(ByteW-1){1'b0}}};

  always_comb begin
    parse_d      = parse_q;
    thr_d        = thr_q;
    yaw_d        = yaw_q;
    pitch_d      = pitch_q;
    trim_d       = trim_q;
    period_cnt_d = period_cnt_q;
    pending_d    = pending_q;
    word_d       = word_q;
    tx_d         = tx_q;
    bits_d       = bits_q;
    seg_cnt_d    = seg_cnt_q;
    upd_d        = 1'b0;
    p_dur        = '0;
    s_dur        = '0;
    seg_sel      = '0;
    p_done       = 1'b0;
    s_done       = 1'b0;
    active       = (tx_q inside {TxHdrMark, TxHdrSpace, TxBitMark, TxBitSpace, TxFooter});

    if (!in_ch.kind) begin
      case (parse_q)
        PsSync:  if (in_ch.rx_byte == SyncByte) parse_d = PsStart;
        PsStart: if (in_ch.rx_byte == StartByte) parse_d = PsThr;
        PsThr: begin
          thr_d   = in_ch.rx_byte;
          parse_d = PsYaw;
        end
        PsYaw: begin
          yaw_d   = in_ch.rx_byte;
          parse_d = PsPitch;
        end
        PsPitch: begin
          pitch_d = in_ch.rx_byte;
          parse_d = PsTrim;
        end
        PsTrim: begin
          trim_d  = in_ch.rx_byte;
          parse_d = PsSync;
          upd_d   = 1'b1;
        end
        default: parse_d = PsSync;
      endcase
    end else begin
      // Frame period timer; a zero period counts as one tick.
      p_dur = PCW'(period_dur_q);
      if (p_dur == '0) p_dur = PCW'(1);
      if (p_dur > PeriodLim) p_dur = PeriodLim;
      p_done = (PCW'(period_cnt_q) + PCW'(1)) >= p_dur;
      period_cnt_d = p_done ? '0 : period_cnt_q + PW'(1);

      if (!active) begin
        tx_d = TxIdle;
        if (p_done || pending_q) begin
          word_d    = {yaw_q, pitch_q, thr_byte, trim_q};
          tx_d      = TxHdrMark;
          bits_d    = FrameBits;
          seg_cnt_d = '0;
          pending_d = 1'b0;
        end
      end else if (p_done) begin
        pending_d = 1'b1;
      end
    end

    // Outputs reflect the phase after any frame start on this tick.
    busy_d = (tx_d inside {TxHdrMark, TxHdrSpace, TxBitMark, TxBitSpace, TxFooter});
    mark_d = (tx_d inside {TxHdrMark, TxBitMark, TxFooter});

    if (in_ch.kind && busy_d) begin
      case (tx_d)
        TxHdrMark:  seg_sel = hdr_mark_q;
        TxHdrSpace: seg_sel = hdr_space_q;
        TxBitMark:  seg_sel = bit_mark_q;
        TxBitSpace: seg_sel = word_d[WordW-1] ? one_space_q : zero_space_q;
        TxFooter:   seg_sel = bit_mark_q;
        default:    seg_sel = SegDurW'(1);
      endcase
      s_dur = SCW'(seg_sel);
      if (s_dur == '0) s_dur = SCW'(1);
      if (s_dur > SegLim) s_dur = SegLim;
      s_done = (SCW'(seg_cnt_d) + SCW'(1)) >= s_dur;

      if (s_done) begin
        seg_cnt_d = '0;
        case (tx_d)
          TxHdrMark:  tx_d = TxHdrSpace;
          TxHdrSpace: tx_d = TxBitMark;
          TxBitMark:  tx_d = TxBitSpace;
          TxBitSpace: begin
            word_d = {word_d[WordW-2:0], 1'b0};
            if (bits_d != '0) bits_d = bits_d - BitCntW'(1);
            tx_d = (bits_d == '0) ? TxFooter : TxBitMark;
          end
          default:    tx_d = TxIdle;
        endcase
      end else begin
        seg_cnt_d = seg_cnt_d + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mark_q   <= HeaderMarkRst;
      hdr_space_q  <= HeaderSpaceRst;
      bit_mark_q   <= BitMarkRst;
      one_space_q  <= OneSpaceRst;
      zero_space_q <= ZeroSpaceRst;
      period_dur_q <= FramePeriodRst;
      channel_q    <= 1'b0;
      parse_q      <= PsSync;
      thr_q        <= ThrottleRst;
      yaw_q        <= AxisRst;
      pitch_q      <= AxisRst;
      trim_q       <= AxisRst;
      period_cnt_q <= '0;
      pending_q    <= 1'b0;
      word_q       <= '0;
      tx_q         <= TxIdle;
      bits_q       <= '0;
      seg_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      mark_q       <= 1'b0;
      busy_q       <= 1'b0;
      upd_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeaderMark:  hdr_mark_q   <= cfg_wdata_i[SegDurW-1:0];
          CfgHeaderSpace: hdr_space_q  <= cfg_wdata_i[SegDurW-1:0];
          CfgBitMark:     bit_mark_q   <= cfg_wdata_i[SegDurW-1:0];
          CfgOneSpace:    one_space_q  <= cfg_wdata_i[SegDurW-1:0];
          CfgZeroSpace:   zero_space_q <= cfg_wdata_i[SegDurW-1:0];
          CfgFramePeriod: period_dur_q <= cfg_wdata_i[PeriodDurW-1:0];
          CfgChannelBit:  channel_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        parse_q      <= parse_d;
        thr_q        <= thr_d;
        yaw_q        <= yaw_d;
        pitch_q      <= pitch_d;
        trim_q       <= trim_d;
        period_cnt_q <= period_cnt_d;
        pending_q    <= pending_d;
        word_q       <= word_d;
        tx_q         <= tx_d;
        bits_q       <= bits_d;
        seg_cnt_q    <= seg_cnt_d;
        mark_q       <= mark_d;
        busy_q       <= busy_d;
        upd_q        <= upd_d;
        out_valid_q  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

endmodule
